// ----- rtl/core/dual_motor_tach_speed_stepper_macros.svh -----
// assertion macros for the dual motor tach speed stepper
// no dependencies; expects clock and reset in the including scope
`ifndef DUAL_MOTOR_TACH_SPEED_STEPPER_MACROS_SVH
`define DUAL_MOTOR_TACH_SPEED_STEPPER_MACROS_SVH

// condition holds at every edge outside reset
`define DMTS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent at the following edge
`define DMTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/dmts_pkg.sv -----
// package for the dual motor tach speed stepper
// beat payload types, sequencer states, register indexes and reset values
`timescale 1ns / 1ps

package dmts_pkg;

   localparam int unsigned RPM_W      = 21;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned DIV_STEPS  = RPM_W;
   localparam int unsigned DIV_CNT_W  = 5;

   localparam logic [15:0] RPM_NUMERATOR = 16'd60000;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RPM   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGNETS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_WINDOW = 3'd3;

   localparam logic [15:0] TARGET_RPM_RST   = 16'd0;
   localparam logic [7:0]  MAGNETS_RST      = 8'd1;
   localparam logic [15:0] HOLD_MS_RST      = 16'd10;
   localparam logic [9:0]  SPEED_WINDOW_RST = 10'd20;

   typedef struct packed {
      logic tick;
      logic pulse_a;
      logic pulse_b;
      logic safety_ok;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] drive_a;
      logic [LEVEL_W-1:0] drive_b;
      logic [RPM_W-1:0]   speed_a;
      logic [RPM_W-1:0]   speed_b;
      logic               at_speed_a;
      logic               at_speed_b;
      logic               ready_res;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MEAS = 7'b0000010,
      ST_DIV  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_SAVE = 7'b0010000,
      ST_STEP = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

// ----- rtl/core/dual_motor_tach_speed_stepper.sv -----
// dual motor tachometer with rate limited bang-bang drive stepping
// uses dmts_pkg and dual_motor_tach_speed_stepper_macros.svh
// a beat is measured per motor; a speed update runs two 21 step divider passes,
// then with safety_ok both drives step, and the result is registered in ST_DONE
// a new beat is taken only after the result is loaded, held back by rsp_stall
// reset: sequencer, per motor state, rsp_valid clear; config takes reset values
`timescale 1ns / 1ps

module dual_motor_tach_speed_stepper #(
   parameter int unsigned PULSES_PER_UPDATE = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dmts_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dmts_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [dmts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmts_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned RW = dmts_pkg::RPM_W;
   localparam int unsigned TW = dmts_pkg::TIME_W;
   localparam int unsigned LW = dmts_pkg::LEVEL_W;
   localparam int unsigned CW = dmts_pkg::COUNT_W;

   // configuration
   logic [15:0] target_ff;
   logic [7:0]  magnets_ff;
   logic [15:0] hold_ff;
   logic [9:0]  window_ff;

   // sequencer and latched beat
   dmts_pkg::state_type state_ff, state_in;
   logic       motor_ff, motor_in;
   logic       phase_ff, phase_in;
   logic [1:0] pulse_ff;
   logic       safe_ff;

   // per motor state
   logic [TW-1:0] now_ff, now_in;
   logic [CW-1:0] count_ff [2];
   logic [TW-1:0] meas_ms_ff [2];
   logic [RW-1:0] rpm_ff [2];
   logic [LW-1:0] level_ff [2];
   logic [TW-1:0] raise_ms_ff [2];
   logic [TW-1:0] lower_ms_ff [2];

   // shared divider
   logic [TW-1:0] rem_ff, rem_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [TW-1:0] dvsr_ff, dvsr_in;
   logic [dmts_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic          rsp_valid_ff;
   dmts_pkg::rsp_type rsp_data_ff;

   logic          req_take;
   logic          out_free;
   logic [CW-1:0] count_next;
   logic [TW-1:0] elapsed;
   logic [TW:0]   rem_sh;
   logic [TW:0]   rem_diff;
   logic          rem_ge;
   logic [RW-1:0] prod;
   logic [TW-1:0] since_lower;
   logic [TW-1:0] since_raise;
   logic          lower_go;
   logic          raise_go;
   logic          in_win_a;
   logic          in_win_b;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != dmts_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign count_next = count_ff[motor_ff] + CW'(1);
   assign elapsed    = now_ff - meas_ms_ff[motor_ff];

   assign rem_sh   = {rem_ff, quo_ff[RW-1]};
   assign rem_ge   = rem_sh >= {1'b0, dvsr_ff};
   assign rem_diff = rem_sh - {1'b0, dvsr_ff};
   assign prod     = RW'(quo_ff[15:0]) * RW'(PULSES_PER_UPDATE);

   assign since_lower = now_ff - lower_ms_ff[motor_ff];
   assign since_raise = now_ff - raise_ms_ff[motor_ff];
   assign lower_go = (RW'(target_ff) < rpm_ff[motor_ff]) && (since_lower >= TW'(hold_ff));
   assign raise_go = (RW'(target_ff) > rpm_ff[motor_ff]) && (since_raise >= TW'(hold_ff));

   assign in_win_a = ((RW+1)'(rpm_ff[0]) <= (RW+1)'(target_ff) + (RW+1)'(window_ff))
                  && ((RW+1)'(rpm_ff[0]) + (RW+1)'(window_ff) >= (RW+1)'(target_ff));
   assign in_win_b = ((RW+1)'(rpm_ff[1]) <= (RW+1)'(target_ff) + (RW+1)'(window_ff))
                  && ((RW+1)'(rpm_ff[1]) + (RW+1)'(window_ff) >= (RW+1)'(target_ff));

   always_comb begin
      state_in   = state_ff;
      motor_in   = motor_ff;
      phase_in   = phase_ff;
      now_in     = now_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvsr_in    = dvsr_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         dmts_pkg::ST_IDLE: begin
            if (req_take) begin
               now_in   = now_ff + TW'(req_data.tick);
               motor_in = 1'b0;
               state_in = dmts_pkg::ST_MEAS;
            end
         end
         dmts_pkg::ST_MEAS: begin
            if (pulse_ff[motor_ff] && (count_next >= CW'(PULSES_PER_UPDATE))) begin
               rem_in     = '0;
               quo_in     = RW'(dmts_pkg::RPM_NUMERATOR);
               dvsr_in    = (elapsed == '0) ? TW'(1) : elapsed;
               div_cnt_in = '0;
               phase_in   = 1'b0;
               state_in   = dmts_pkg::ST_DIV;
            end else if (motor_ff) begin
               motor_in = 1'b0;
               state_in = safe_ff ? dmts_pkg::ST_STEP : dmts_pkg::ST_DONE;
            end else begin
               motor_in = 1'b1;
            end
         end
         dmts_pkg::ST_DIV: begin
            rem_in     = rem_ge ? rem_diff[TW-1:0] : rem_sh[TW-1:0];
            quo_in     = {quo_ff[RW-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == dmts_pkg::DIV_CNT_W'(dmts_pkg::DIV_STEPS - 1)) begin
               state_in = phase_ff ? dmts_pkg::ST_SAVE : dmts_pkg::ST_MUL;
            end
         end
         dmts_pkg::ST_MUL: begin
            rem_in     = '0;
            quo_in     = prod;
            dvsr_in    = (magnets_ff == '0) ? TW'(1) : TW'(magnets_ff);
            div_cnt_in = '0;
            phase_in   = 1'b1;
            state_in   = dmts_pkg::ST_DIV;
         end
         dmts_pkg::ST_SAVE: begin
            if (motor_ff) begin
               motor_in = 1'b0;
               state_in = safe_ff ? dmts_pkg::ST_STEP : dmts_pkg::ST_DONE;
            end else begin
               motor_in = 1'b1;
               state_in = dmts_pkg::ST_MEAS;
            end
         end
         dmts_pkg::ST_STEP: begin
            motor_in = 1'b1;
            if (motor_ff) begin
               state_in = dmts_pkg::ST_DONE;
            end
         end
         dmts_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = dmts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmts_pkg::ST_IDLE;
         motor_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         now_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= dmts_pkg::TARGET_RPM_RST;
         magnets_ff   <= dmts_pkg::MAGNETS_RST;
         hold_ff      <= dmts_pkg::HOLD_MS_RST;
         window_ff    <= dmts_pkg::SPEED_WINDOW_RST;
         for (int m = 0; m < 2; m++) begin
            count_ff[m]    <= '0;
            meas_ms_ff[m]  <= '0;
            rpm_ff[m]      <= '0;
            level_ff[m]    <= '0;
            raise_ms_ff[m] <= '0;
            lower_ms_ff[m] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         motor_ff   <= motor_in;
         phase_ff   <= phase_in;
         now_ff     <= now_in;
         div_cnt_ff <= div_cnt_in;

         if (csr_we) begin
            case (csr_index)
               dmts_pkg::CSR_TARGET_RPM:   target_ff  <= csr_wdata;
               dmts_pkg::CSR_MAGNETS:      magnets_ff <= csr_wdata[7:0];
               dmts_pkg::CSR_HOLD_MS:      hold_ff    <= csr_wdata;
               dmts_pkg::CSR_SPEED_WINDOW: window_ff  <= csr_wdata[9:0];
               default: ;
            endcase
         end

         if (state_ff == dmts_pkg::ST_MEAS && pulse_ff[motor_ff]
             && (count_next < CW'(PULSES_PER_UPDATE))) begin
            count_ff[motor_ff] <= count_next;
         end

         if (state_ff == dmts_pkg::ST_SAVE) begin
            rpm_ff[motor_ff]     <= quo_ff;
            meas_ms_ff[motor_ff] <= now_ff;
            count_ff[motor_ff]   <= '0;
         end

         if (state_ff == dmts_pkg::ST_STEP) begin
            if (lower_go) begin
               if (level_ff[motor_ff] != '0) begin
                  level_ff[motor_ff] <= level_ff[motor_ff] - LW'(1);
               end
               lower_ms_ff[motor_ff] <= now_ff;
            end else if (raise_go) begin
               if (level_ff[motor_ff] != '1) begin
                  level_ff[motor_ff] <= level_ff[motor_ff] + LW'(1);
               end
               raise_ms_ff[motor_ff] <= now_ff;
            end
         end

         if (state_ff == dmts_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      if (req_take) begin
         pulse_ff <= {req_data.pulse_b, req_data.pulse_a};
         safe_ff  <= req_data.safety_ok;
      end
      if (state_ff == dmts_pkg::ST_DONE && out_free) begin
         rsp_data_ff.drive_a    <= safe_ff ? level_ff[0] : '0;
         rsp_data_ff.drive_b    <= safe_ff ? level_ff[1] : '0;
         rsp_data_ff.speed_a    <= rpm_ff[0];
         rsp_data_ff.speed_b    <= rpm_ff[1];
         rsp_data_ff.at_speed_a <= in_win_a;
         rsp_data_ff.at_speed_b <= in_win_b;
         rsp_data_ff.ready_res  <= in_win_a && in_win_b;
      end
   end

`include "dual_motor_tach_speed_stepper_macros.svh"

   `DMTS_ASSERT_NEXT(a_busy_after_accept, req_take, req_stall, "no busy after accepted beat")
   `DMTS_ASSERT_NEXT(a_result_loaded, (state_ff == dmts_pkg::ST_DONE) && out_free, rsp_valid, "result beat not presented")
   `DMTS_ASSERT_ALWAYS(a_div_count, (state_ff != dmts_pkg::ST_DIV) || (div_cnt_ff < dmts_pkg::DIV_CNT_W'(dmts_pkg::DIV_STEPS)), "divider step count overrun")

endmodule

// ----- tb/tb_dual_motor_tach_speed_stepper.sv -----
// self-checking testbench for dual_motor_tach_speed_stepper
// tracks ms time, pulse counts, measured rpm and drive levels per beat and checks every result
// depends on dmts_pkg and the dual_motor_tach_speed_stepper rtl
`timescale 1ns / 1ps

module tb_dual_motor_tach_speed_stepper;

   localparam int unsigned PULSES_PER_UPDATE = 20;
   localparam int unsigned MOTOR_A = 0;
   localparam int unsigned MOTOR_B = 1;
   localparam longint unsigned RPM_MAX = (64'd1 << dmts_pkg::RPM_W) - 1;
   localparam logic [dmts_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO =
      dmts_pkg::CSR_SPEED_WINDOW + 3'd1;
   localparam int unsigned CSR_INDEX_TOP = (1 << dmts_pkg::CSR_IDX_W) - 1;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned MAX_LATENCY = 100;

   class tach_speed_tracker;
      logic [15:0] target_rpm;
      logic [7:0] magnets;
      logic [15:0] hold_ms;
      logic [9:0] window;
      logic [31:0] now_ms;
      logic [dmts_pkg::COUNT_W-1:0] pulse_cnt [2];
      logic [31:0] last_measure [2];
      logic [dmts_pkg::RPM_W-1:0] rpm [2];
      logic [dmts_pkg::LEVEL_W-1:0] level [2];
      logic [31:0] last_raise [2];
      logic [31:0] last_lower [2];
      dmts_pkg::rsp_type pending_status [$];
      int unsigned failures;

      function new();
         target_rpm = dmts_pkg::TARGET_RPM_RST;
         magnets = dmts_pkg::MAGNETS_RST;
         hold_ms = dmts_pkg::HOLD_MS_RST;
         window = dmts_pkg::SPEED_WINDOW_RST;
         now_ms = '0;
         failures = 0;
         for (int m = 0; m < 2; m++) begin
            pulse_cnt[m] = '0;
            last_measure[m] = '0;
            rpm[m] = '0;
            level[m] = '0;
            last_raise[m] = '0;
            last_lower[m] = '0;
         end
      endfunction

      function void write_reg(logic [dmts_pkg::CSR_IDX_W-1:0] idx,
                              logic [dmts_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            dmts_pkg::CSR_TARGET_RPM: target_rpm = data[15:0];
            dmts_pkg::CSR_MAGNETS: magnets = data[7:0];
            dmts_pkg::CSR_HOLD_MS: hold_ms = data[15:0];
            dmts_pkg::CSR_SPEED_WINDOW: window = data[9:0];
            default: ;
         endcase
      endfunction

      function void measure(int unsigned m);
         logic [31:0] elapsed;
         int unsigned quot;
         int unsigned mag;
         longint unsigned speed;
         pulse_cnt[m] = pulse_cnt[m] + 1'b1;
         if (pulse_cnt[m] < PULSES_PER_UPDATE) return;
         elapsed = now_ms - last_measure[m];
         if (elapsed == 0) elapsed = 1;
         mag = (magnets == 0) ? 1 : magnets;
         quot = dmts_pkg::RPM_NUMERATOR / elapsed;
         speed = quot;
         speed = speed * pulse_cnt[m] / mag;
         if (speed > RPM_MAX) speed = RPM_MAX;
         rpm[m] = speed[dmts_pkg::RPM_W-1:0];
         last_measure[m] = now_ms;
         pulse_cnt[m] = '0;
      endfunction

      function void step_level(int unsigned m);
         logic [31:0] since_lower;
         logic [31:0] since_raise;
         since_lower = now_ms - last_lower[m];
         since_raise = now_ms - last_raise[m];
         if (target_rpm < rpm[m] && since_lower >= hold_ms) begin
            if (level[m] != 0) level[m] = level[m] - 1'b1;
            last_lower[m] = now_ms;
         end else if (target_rpm > rpm[m] && since_raise >= hold_ms) begin
            if (level[m] != '1) level[m] = level[m] + 1'b1;
            last_raise[m] = now_ms;
         end
      endfunction

      function bit on_target(int unsigned m);
         int unsigned r;
         int unsigned t;
         int unsigned w;
         r = rpm[m];
         t = target_rpm;
         w = window;
         return (r <= t + w) && (r + w >= t);
      endfunction

      function void take_beat(dmts_pkg::req_type beat);
         dmts_pkg::rsp_type st;
         bit hit_a;
         bit hit_b;
         if (beat.tick) now_ms = now_ms + 1;
         if (beat.pulse_a) measure(MOTOR_A);
         if (beat.pulse_b) measure(MOTOR_B);
         if (beat.safety_ok) begin
            step_level(MOTOR_A);
            step_level(MOTOR_B);
         end
         hit_a = on_target(MOTOR_A);
         hit_b = on_target(MOTOR_B);
         st.drive_a = beat.safety_ok ? level[MOTOR_A] : '0;
         st.drive_b = beat.safety_ok ? level[MOTOR_B] : '0;
         st.speed_a = rpm[MOTOR_A];
         st.speed_b = rpm[MOTOR_B];
         st.at_speed_a = hit_a;
         st.at_speed_b = hit_b;
         st.ready_res = hit_a & hit_b;
         pending_status.push_back(st);
      endfunction

      task report(string what);
         failures++;
         if (failures <= 100) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_status(dmts_pkg::rsp_type got);
         dmts_pkg::rsp_type want;
         if (pending_status.size() == 0) begin
            report("result beat with nothing pending");
            return;
         end
         want = pending_status.pop_front();
         if (got.drive_a !== want.drive_a)
            report($sformatf("drive_a got %0d want %0d", got.drive_a, want.drive_a));
         if (got.drive_b !== want.drive_b)
            report($sformatf("drive_b got %0d want %0d", got.drive_b, want.drive_b));
         if (got.speed_a !== want.speed_a)
            report($sformatf("speed_a got %0d want %0d", got.speed_a, want.speed_a));
         if (got.speed_b !== want.speed_b)
            report($sformatf("speed_b got %0d want %0d", got.speed_b, want.speed_b));
         if (got.at_speed_a !== want.at_speed_a)
            report($sformatf("at_speed_a got %b want %b", got.at_speed_a, want.at_speed_a));
         if (got.at_speed_b !== want.at_speed_b)
            report($sformatf("at_speed_b got %b want %b", got.at_speed_b, want.at_speed_b));
         if (got.ready_res !== want.ready_res)
            report($sformatf("ready_res got %b want %b", got.ready_res, want.ready_res));
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dmts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dmts_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [dmts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dmts_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tach_speed_tracker tracker;
   int unsigned send_idle_pct = 18;
   int unsigned recv_idle_pct = 18;
   bit hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycles = 0;

   dual_motor_tach_speed_stepper #(
      .PULSES_PER_UPDATE(PULSES_PER_UPDATE)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side, with a long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_status(rsp_data);
      if (hold_request) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      if (hold_left > 0) hold_left--;
   end

   task automatic send_beat(input bit t, input bit pa, input bit pb, input bit s);
      dmts_pkg::req_type beat;
      beat.tick = t;
      beat.pulse_a = pa;
      beat.pulse_b = pb;
      beat.safety_ok = s;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_beat(beat);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dmts_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dmts_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned tgt, input int unsigned mag,
                            input int unsigned hold, input int unsigned win);
      logic [dmts_pkg::CSR_DATA_W-1:0] junk;
      logic [dmts_pkg::CSR_IDX_W-1:0] spare_idx;
      drain();
      junk = dmts_pkg::CSR_DATA_W'($urandom);
      spare_idx = dmts_pkg::CSR_IDX_W'($urandom_range(CSR_INDEX_TOP, CSR_UNMAPPED_LO));
      write_csr(dmts_pkg::CSR_TARGET_RPM, tgt[15:0]);
      write_csr(dmts_pkg::CSR_MAGNETS, {junk[15:8], mag[7:0]});
      write_csr(dmts_pkg::CSR_HOLD_MS, hold[15:0]);
      write_csr(dmts_pkg::CSR_SPEED_WINDOW, {junk[5:0], win[9:0]});
      write_csr(spare_idx, ~junk);
   endtask

   task automatic run_phase(input int unsigned n, input int unsigned pt, input int unsigned pa,
                            input int unsigned pb, input int unsigned ps);
      repeat (n) begin
         send_beat($urandom_range(99) < pt, $urandom_range(99) < pa,
                   $urandom_range(99) < pb, $urandom_range(99) < ps);
      end
   endtask

   initial begin
      int unsigned pt;
      int unsigned pa;
      int unsigned pb;
      int unsigned mag;
      int unsigned est;
      int unsigned tgt;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings; twenty pulses before any tick give a zero elapsed time
      send_beat(1'b0, 1'b0, 1'b0, 1'b0);
      send_beat(1'b0, 1'b0, 1'b0, 1'b1);
      for (int i = 0; i < PULSES_PER_UPDATE; i++) send_beat(1'b0, 1'b1, 1'b1, i[0]);
      send_beat(1'b1, 1'b1, 1'b0, 1'b0);
      send_beat(1'b1, 1'b0, 1'b1, 1'b1);
      send_beat(1'b1, 1'b1, 1'b1, 1'b1);

      // no idling: drive lowers at zero, then climbs toward full scale
      configure(16'hffff, 1, 0, 1023);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(320, 90, 30, 35, 100);
      send_idle_pct = 18;
      recv_idle_pct = 18;

      configure(0, 255, 0, 0);
      run_phase(130, 70, 50, 40, 85);

      // zero magnets count as one
      configure(38000 + $urandom_range(4000), 0, 3, 50);
      run_phase(130, 60, 40, 45, 90);

      configure($urandom_range(16'hffff), $urandom_range(8, 2), 16'hffff,
                $urandom_range(1023));
      hold_request = 1'b1;
      run_phase(100, 50, 30, 30, 90);

      for (int p = 0; p < 5; p++) begin
         pt = $urandom_range(95, 40);
         pa = $urandom_range(60, 10);
         pb = $urandom_range(60, 10);
         mag = $urandom_range(6, 1);
         est = dmts_pkg::RPM_NUMERATOR * pa / pt / mag;
         tgt = est + $urandom_range(300) - 150;
         if (tgt > 16'hffff) tgt = 16'hffff;
         configure(tgt, mag, $urandom_range(15), $urandom_range(1023));
         run_phase(120, pt, pa, pb, $urandom_range(100, 70));
      end

      drain();
      repeat (MAX_LATENCY) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
